// ----- hdl/cfir_pkg.sv -----
`default_nettype none

package cfir_pkg;

    // Build defaults for the top-level parameters.
    localparam int DEF_MAX_TAPS     = 1024;
    localparam int DEF_SAMPLE_WIDTH = 16;
    localparam int DEF_COEFF_WIDTH  = 16;

    // Fixed field widths of the stream items and the register.
    localparam int COEFF_INDEX_WIDTH = 10;
    localparam int TAP_FIELD_WIDTH   = 11;
    localparam int RESET_TAPS        = 64;

    // Configuration port geometry.
    localparam int APB_ADDR_WIDTH = 3;
    localparam int APB_DATA_WIDTH = 32;

    // Register indexes, taken from paddr above the byte offset.
    localparam logic REG_TAP_COUNT = 1'b0;

    // Item kinds carried in s_tuser.
    typedef enum logic
    {
        OP_FILTER = 1'b0,
        OP_LOAD   = 1'b1
    } opcode_t;

    // Commands from the sequencer to the shared MAC unit.
    typedef struct packed
    {
        logic clear;    // start a new sum
        logic tap_vld;  // read data of one tap is present this cycle
        logic zero;     // that tap lies past the filled part of the delay line
        logic round;    // add the rounding bias to the finished sum
    } mac_ctl_t;

endpackage

`default_nettype wire

// ----- hdl/cfir_regs.sv -----
`default_nettype none

module cfir_regs #(
    parameter int MAX_TAPS = cfir_pkg::DEF_MAX_TAPS
) (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic                                psel,
    input  wire logic                                penable,
    input  wire logic                                pwrite,
    input  wire logic [cfir_pkg::APB_ADDR_WIDTH-1:0] paddr,
    input  wire logic [cfir_pkg::APB_DATA_WIDTH-1:0] pwdata,
    output logic      [cfir_pkg::APB_DATA_WIDTH-1:0] prdata,
    output logic                                     pready,
    output logic      [$clog2(MAX_TAPS+1)-1:0]       tap_count,
    output logic                                     taps_changed
);

    localparam int TCW = $clog2(MAX_TAPS + 1);
    localparam int RESET_LIMITED =
        (cfir_pkg::RESET_TAPS > MAX_TAPS) ? MAX_TAPS : cfir_pkg::RESET_TAPS;

    logic [TCW-1:0]                            tap_count_reg;
    logic [TCW-1:0]                            tap_count_next;
    logic [cfir_pkg::TAP_FIELD_WIDTH-1:0]      wr_field;
    logic [TCW-1:0]                            wr_limited;
    logic                                      wr_en;
    logic                                      sel_tap_count;

    assign pready        = 1'b1;
    assign sel_tap_count = (paddr[cfir_pkg::APB_ADDR_WIDTH-1] == cfir_pkg::REG_TAP_COUNT);
    assign wr_en         = psel && penable && pwrite && pready && sel_tap_count;
    assign wr_field      = pwdata[cfir_pkg::TAP_FIELD_WIDTH-1:0];

    // Saturate the written tap count into the range 1 to MAX_TAPS.
    always_comb
    begin
        if (wr_field == '0)
        begin
            wr_limited = TCW'(1);
        end
        else if (32'(wr_field) > 32'(MAX_TAPS))
        begin
            wr_limited = TCW'(MAX_TAPS);
        end
        else
        begin
            wr_limited = TCW'(wr_field);
        end
    end

    // A write that changes the value in use restarts the delay lines.
    always_comb
    begin
        tap_count_next = tap_count_reg;
        taps_changed   = 1'b0;
        if (wr_en && (wr_limited != tap_count_reg))
        begin
            tap_count_next = wr_limited;
            taps_changed   = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tap_count_reg <= TCW'(RESET_LIMITED);
        end
        else
        begin
            tap_count_reg <= tap_count_next;
        end
    end

    assign tap_count = tap_count_reg;
    assign prdata    = sel_tap_count ? cfir_pkg::APB_DATA_WIDTH'(tap_count_reg) : '0;

endmodule

`default_nettype wire

// ----- hdl/cfir_store.sv -----
`default_nettype none

module cfir_store #(
    parameter int MAX_TAPS     = cfir_pkg::DEF_MAX_TAPS,
    parameter int SAMPLE_WIDTH = cfir_pkg::DEF_SAMPLE_WIDTH,
    parameter int COEFF_WIDTH  = cfir_pkg::DEF_COEFF_WIDTH
) (
    input  wire logic                        clk,
    input  wire logic                        dl_we,
    input  wire logic [$clog2(MAX_TAPS)-1:0] dl_waddr,
    input  wire logic [SAMPLE_WIDTH-1:0]     dl_wdata_i,
    input  wire logic [SAMPLE_WIDTH-1:0]     dl_wdata_q,
    input  wire logic                        cf_we,
    input  wire logic [$clog2(MAX_TAPS)-1:0] cf_waddr,
    input  wire logic [COEFF_WIDTH-1:0]      cf_wdata,
    input  wire logic                        rd_en,
    input  wire logic [$clog2(MAX_TAPS)-1:0] dl_raddr,
    input  wire logic [$clog2(MAX_TAPS)-1:0] cf_raddr,
    output logic      [SAMPLE_WIDTH-1:0]     rd_i,
    output logic      [SAMPLE_WIDTH-1:0]     rd_q,
    output logic      [COEFF_WIDTH-1:0]      rd_c
);

    logic [SAMPLE_WIDTH-1:0] delay_i_mem [MAX_TAPS];
    logic [SAMPLE_WIDTH-1:0] delay_q_mem [MAX_TAPS];
    logic [COEFF_WIDTH-1:0]  coeff_mem   [MAX_TAPS];
    logic [SAMPLE_WIDTH-1:0] rd_i_reg;
    logic [SAMPLE_WIDTH-1:0] rd_q_reg;
    logic [COEFF_WIDTH-1:0]  rd_c_reg;

    // Delay lines: one write port for the newest pair, one registered read port.
    always_ff @(posedge clk)
    begin
        if (dl_we)
        begin
            delay_i_mem[dl_waddr] <= dl_wdata_i;
            delay_q_mem[dl_waddr] <= dl_wdata_q;
        end
        if (rd_en)
        begin
            rd_i_reg <= delay_i_mem[dl_raddr];
            rd_q_reg <= delay_q_mem[dl_raddr];
        end
    end

    // Coefficient store, shared by both channels.
    always_ff @(posedge clk)
    begin
        if (cf_we)
        begin
            coeff_mem[cf_waddr] <= cf_wdata;
        end
        if (rd_en)
        begin
            rd_c_reg <= coeff_mem[cf_raddr];
        end
    end

    assign rd_i = rd_i_reg;
    assign rd_q = rd_q_reg;
    assign rd_c = rd_c_reg;

endmodule

`default_nettype wire

// ----- hdl/cfir_mac.sv -----
`default_nettype none

module cfir_mac #(
    parameter int MAX_TAPS     = cfir_pkg::DEF_MAX_TAPS,
    parameter int SAMPLE_WIDTH = cfir_pkg::DEF_SAMPLE_WIDTH,
    parameter int COEFF_WIDTH  = cfir_pkg::DEF_COEFF_WIDTH
) (
    input  wire logic                     clk,
    input  wire logic                     rst_n,
    input  wire cfir_pkg::mac_ctl_t       ctl,
    input  wire logic [SAMPLE_WIDTH-1:0]  rd_i,
    input  wire logic [SAMPLE_WIDTH-1:0]  rd_q,
    input  wire logic [COEFF_WIDTH-1:0]   rd_c,
    output logic      [SAMPLE_WIDTH-1:0]  res_i,
    output logic      [SAMPLE_WIDTH-1:0]  res_q
);

    localparam int PW    = SAMPLE_WIDTH + COEFF_WIDTH;
    localparam int FULLW = PW + $clog2(MAX_TAPS);
    localparam int ACC_W = (FULLW > 64) ? 64 : FULLW;
    localparam logic signed [ACC_W-1:0] ROUND_BIAS =
        {{(ACC_W-1){1'b0}}, 1'b1} << (COEFF_WIDTH - 2);
    localparam logic signed [ACC_W-1:0] SAT_MAX =
        {{(ACC_W-SAMPLE_WIDTH+1){1'b0}}, {(SAMPLE_WIDTH-1){1'b1}}};
    localparam logic signed [ACC_W-1:0] SAT_MIN = ~SAT_MAX;

    logic signed [SAMPLE_WIDTH-1:0] x_i;
    logic signed [SAMPLE_WIDTH-1:0] x_q;
    logic signed [COEFF_WIDTH-1:0]  c;
    logic signed [PW-1:0]           prod_i;
    logic signed [PW-1:0]           prod_q;
    logic signed [PW-1:0]           prod_i_reg;
    logic signed [PW-1:0]           prod_q_reg;
    logic                           prod_vld_reg;
    logic signed [ACC_W-1:0]        acc_i_reg;
    logic signed [ACC_W-1:0]        acc_q_reg;
    logic signed [ACC_W-1:0]        rnd_i_reg;
    logic signed [ACC_W-1:0]        rnd_q_reg;

    // Shift right by the coefficient fraction bits and clamp to the sample range.
    function automatic logic [SAMPLE_WIDTH-1:0] shift_sat(input logic signed [ACC_W-1:0] v);
        logic signed [ACC_W-1:0] sh;
        sh = v >>> (COEFF_WIDTH - 1);
        if (sh > SAT_MAX)
        begin
            return SAT_MAX[SAMPLE_WIDTH-1:0];
        end
        else if (sh < SAT_MIN)
        begin
            return SAT_MIN[SAMPLE_WIDTH-1:0];
        end
        return sh[SAMPLE_WIDTH-1:0];
    endfunction

    assign x_i = ctl.zero ? '0 : $signed(rd_i);
    assign x_q = ctl.zero ? '0 : $signed(rd_q);
    assign c   = $signed(rd_c);

    // Multiplier stage: one tap of each channel per cycle.
    assign prod_i = x_i * c;
    assign prod_q = x_q * c;

    always_ff @(posedge clk)
    begin
        prod_i_reg <= prod_i;
        prod_q_reg <= prod_q;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prod_vld_reg <= 1'b0;
        end
        else
        begin
            prod_vld_reg <= ctl.tap_vld;
        end
    end

    // Accumulator stage, then the rounding add once the sum is complete.
    always_ff @(posedge clk)
    begin
        if (ctl.clear)
        begin
            acc_i_reg <= '0;
            acc_q_reg <= '0;
        end
        else if (prod_vld_reg)
        begin
            acc_i_reg <= acc_i_reg + ACC_W'(prod_i_reg);
            acc_q_reg <= acc_q_reg + ACC_W'(prod_q_reg);
        end
        if (ctl.round)
        begin
            rnd_i_reg <= acc_i_reg + ROUND_BIAS;
            rnd_q_reg <= acc_q_reg + ROUND_BIAS;
        end
    end

    assign res_i = shift_sat(rnd_i_reg);
    assign res_q = shift_sat(rnd_q_reg);

endmodule

`default_nettype wire

// ----- hdl/cfir_ctrl.sv -----
`default_nettype none

module cfir_ctrl #(
    parameter int MAX_TAPS     = cfir_pkg::DEF_MAX_TAPS,
    parameter int SAMPLE_WIDTH = cfir_pkg::DEF_SAMPLE_WIDTH,
    parameter int COEFF_WIDTH  = cfir_pkg::DEF_COEFF_WIDTH
) (
    input  wire logic                                   clk,
    input  wire logic                                   rst_n,
    // Input items
    input  wire logic                                   s_tvalid,
    output logic                                        s_tready,
    input  wire cfir_pkg::opcode_t                      opcode,
    input  wire logic [SAMPLE_WIDTH-1:0]                sample_i,
    input  wire logic [SAMPLE_WIDTH-1:0]                sample_q,
    input  wire logic [cfir_pkg::COEFF_INDEX_WIDTH-1:0] coeff_index,
    input  wire logic [COEFF_WIDTH-1:0]                 coeff_value,
    // Configuration
    input  wire logic [$clog2(MAX_TAPS+1)-1:0]          tap_count,
    input  wire logic                                   taps_changed,
    // Storage
    output logic                                        dl_we,
    output logic      [$clog2(MAX_TAPS)-1:0]            dl_waddr,
    output logic      [SAMPLE_WIDTH-1:0]                dl_wdata_i,
    output logic      [SAMPLE_WIDTH-1:0]                dl_wdata_q,
    output logic                                        cf_we,
    output logic      [$clog2(MAX_TAPS)-1:0]            cf_waddr,
    output logic      [COEFF_WIDTH-1:0]                 cf_wdata,
    output logic                                        rd_en,
    output logic      [$clog2(MAX_TAPS)-1:0]            dl_raddr,
    output logic      [$clog2(MAX_TAPS)-1:0]            cf_raddr,
    // MAC unit
    output cfir_pkg::mac_ctl_t                          mac_ctl,
    input  wire logic [SAMPLE_WIDTH-1:0]                res_i,
    input  wire logic [SAMPLE_WIDTH-1:0]                res_q,
    // Result items
    output logic                                        m_tvalid,
    input  wire logic                                   m_tready,
    output logic      [((2*SAMPLE_WIDTH+7)/8)*8-1:0]    m_tdata
);

    localparam int AW    = $clog2(MAX_TAPS);
    localparam int TCW   = $clog2(MAX_TAPS + 1);
    localparam int OUT_W = ((2 * SAMPLE_WIDTH + 7) / 8) * 8;

    typedef enum logic [4:0]
    {
        S_IDLE  = 5'b00001,
        S_RUN   = 5'b00010,
        S_DRAIN = 5'b00100,
        S_ROUND = 5'b01000,
        S_DONE  = 5'b10000
    } state_t;

    state_t            state_reg;
    state_t            state_next;
    logic [AW-1:0]     newest_reg;
    logic [AW-1:0]     newest_next;
    logic [TCW-1:0]    fill_reg;
    logic [TCW-1:0]    fill_next;
    logic [AW-1:0]     k_reg;
    logic [AW-1:0]     k_next;
    logic [AW-1:0]     pos_reg;
    logic [AW-1:0]     pos_next;
    logic              drain_reg;
    logic              drain_next;
    logic              tap_vld_reg;
    logic              zero_reg;
    logic              out_vld_reg;
    logic              out_vld_next;
    logic [OUT_W-1:0]  out_data_reg;
    logic [OUT_W-1:0]  out_data_next;

    logic              accept;
    logic              sample_acc;
    logic              load_acc;
    logic [TCW-1:0]    newest_base;
    logic [AW-1:0]     newest_new;
    logic [TCW-1:0]    pos_inc;
    logic              last_tap;
    logic              tap_zero;

    assign s_tready   = (state_reg == S_IDLE);
    assign accept     = s_tvalid && s_tready;
    assign sample_acc = accept && (opcode == cfir_pkg::OP_FILTER);
    assign load_acc   = accept && (opcode == cfir_pkg::OP_LOAD);

    // Step the newest slot back by one around a ring of tap_count entries.
    assign newest_base = (TCW'(newest_reg) >= tap_count) ? '0 : TCW'(newest_reg);
    assign newest_new  = (newest_base == '0) ? AW'(tap_count - TCW'(1))
                                             : AW'(newest_base - TCW'(1));

    // Tap walk: slot advances with wrap, k counts taps from the newest sample.
    assign pos_inc  = TCW'(pos_reg) + TCW'(1);
    assign last_tap = (TCW'(k_reg) == (tap_count - TCW'(1)));
    assign tap_zero = (TCW'(k_reg) >= fill_reg);

    // Storage writes happen at acceptance; reads run through the walk.
    assign dl_we      = sample_acc;
    assign dl_waddr   = newest_new;
    assign dl_wdata_i = sample_i;
    assign dl_wdata_q = sample_q;
    assign cf_we      = load_acc && (32'(coeff_index) < 32'(MAX_TAPS));
    assign cf_waddr   = AW'(coeff_index);
    assign cf_wdata   = coeff_value;
    assign rd_en      = (state_reg == S_RUN);
    assign dl_raddr   = pos_reg;
    assign cf_raddr   = k_reg;

    assign mac_ctl.clear   = sample_acc;
    assign mac_ctl.tap_vld = tap_vld_reg;
    assign mac_ctl.zero    = zero_reg;
    assign mac_ctl.round   = (state_reg == S_ROUND);

    // Sequencer.
    always_comb
    begin
        state_next    = state_reg;
        newest_next   = newest_reg;
        fill_next     = fill_reg;
        k_next        = k_reg;
        pos_next      = pos_reg;
        drain_next    = drain_reg;
        out_vld_next  = out_vld_reg;
        out_data_next = out_data_reg;

        if (m_tvalid && m_tready)
        begin
            out_vld_next = 1'b0;
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (sample_acc)
                begin
                    newest_next = newest_new;
                    pos_next    = newest_new;
                    k_next      = '0;
                    if (fill_reg < tap_count)
                    begin
                        fill_next = fill_reg + TCW'(1);
                    end
                    state_next  = S_RUN;
                end
            end
            S_RUN:
            begin
                k_next   = k_reg + AW'(1);
                pos_next = (pos_inc == tap_count) ? '0 : AW'(pos_inc);
                if (last_tap)
                begin
                    drain_next = 1'b0;
                    state_next = S_DRAIN;
                end
            end
            S_DRAIN:
            begin
                drain_next = 1'b1;
                if (drain_reg)
                begin
                    state_next = S_ROUND;
                end
            end
            S_ROUND:
            begin
                state_next = S_DONE;
            end
            S_DONE:
            begin
                if (!out_vld_reg || m_tready)
                begin
                    out_vld_next  = 1'b1;
                    out_data_next = OUT_W'({res_q, res_i});
                    state_next    = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        // A new tap count empties both delay lines.
        if (taps_changed)
        begin
            newest_next = '0;
            fill_next   = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_IDLE;
            newest_reg  <= '0;
            fill_reg    <= '0;
            k_reg       <= '0;
            pos_reg     <= '0;
            drain_reg   <= 1'b0;
            tap_vld_reg <= 1'b0;
            zero_reg    <= 1'b0;
            out_vld_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            newest_reg  <= newest_next;
            fill_reg    <= fill_next;
            k_reg       <= k_next;
            pos_reg     <= pos_next;
            drain_reg   <= drain_next;
            tap_vld_reg <= rd_en;
            zero_reg    <= tap_zero;
            out_vld_reg <= out_vld_next;
        end
    end

    // Output register parts the result from the next item's work.
    always_ff @(posedge clk)
    begin
        out_data_reg <= out_data_next;
    end

    assign m_tvalid = out_vld_reg;
    assign m_tdata  = out_data_reg;

endmodule

`default_nettype wire

// ----- hdl/complex_fir_filter_core.sv -----
// Complex FIR filter for I/Q baseband: both channels share one set of real
// coefficients, loaded one tap per load item (s_tuser high) before samples flow.
// A sample item (s_tuser low) gives one filtered pair from one multiply-accumulate
// unit per channel that walks the taps one per cycle from the delay-line and
// coefficient memories; a load item is written at acceptance and leaves s_tready
// high. s_tready stays low while a sample is being filtered, and the result
// waits in an output register. Results are rounded, shifted right by
// COEFF_WIDTH-1 and saturated. Register tap_count (byte address 0) is clamped
// to 1..MAX_TAPS; writing a different value empties both delay lines at once,
// and it may be written only while the block is idle.
`default_nettype none

module complex_fir_filter_core #(
    parameter int MAX_TAPS     = cfir_pkg::DEF_MAX_TAPS,
    parameter int SAMPLE_WIDTH = cfir_pkg::DEF_SAMPLE_WIDTH,
    parameter int COEFF_WIDTH  = cfir_pkg::DEF_COEFF_WIDTH
) (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    // Configuration port
    input  wire logic                                psel,
    input  wire logic                                penable,
    input  wire logic                                pwrite,
    input  wire logic [cfir_pkg::APB_ADDR_WIDTH-1:0] paddr,
    input  wire logic [cfir_pkg::APB_DATA_WIDTH-1:0] pwdata,
    output logic      [cfir_pkg::APB_DATA_WIDTH-1:0] prdata,
    output logic                                     pready,
    // Input stream
    input  wire logic                                s_tvalid,
    output logic                                     s_tready,
    // s_tdata, from bit 0: sample_i, sample_q, coeff_index, coeff_value, zero fill
    input  wire logic [((2*SAMPLE_WIDTH+cfir_pkg::COEFF_INDEX_WIDTH+COEFF_WIDTH+7)/8)*8-1:0]
                                                     s_tdata,
    // s_tuser: opcode
    input  wire logic                                s_tuser,
    // Output stream
    output logic                                     m_tvalid,
    input  wire logic                                m_tready,
    // m_tdata, from bit 0: filtered_i, filtered_q, zero fill
    output logic      [((2*SAMPLE_WIDTH+7)/8)*8-1:0] m_tdata
);

    localparam int AW       = $clog2(MAX_TAPS);
    localparam int TCW      = $clog2(MAX_TAPS + 1);
    localparam int IDX_LO   = 2 * SAMPLE_WIDTH;
    localparam int VAL_LO   = IDX_LO + cfir_pkg::COEFF_INDEX_WIDTH;

    logic [SAMPLE_WIDTH-1:0]                sample_i;
    logic [SAMPLE_WIDTH-1:0]                sample_q;
    logic [cfir_pkg::COEFF_INDEX_WIDTH-1:0] coeff_index;
    logic [COEFF_WIDTH-1:0]                 coeff_value;
    cfir_pkg::opcode_t                      opcode;

    logic [TCW-1:0]          tap_count;
    logic                    taps_changed;
    logic                    dl_we;
    logic [AW-1:0]           dl_waddr;
    logic [SAMPLE_WIDTH-1:0] dl_wdata_i;
    logic [SAMPLE_WIDTH-1:0] dl_wdata_q;
    logic                    cf_we;
    logic [AW-1:0]           cf_waddr;
    logic [COEFF_WIDTH-1:0]  cf_wdata;
    logic                    rd_en;
    logic [AW-1:0]           dl_raddr;
    logic [AW-1:0]           cf_raddr;
    logic [SAMPLE_WIDTH-1:0] rd_i;
    logic [SAMPLE_WIDTH-1:0] rd_q;
    logic [COEFF_WIDTH-1:0]  rd_c;
    cfir_pkg::mac_ctl_t      mac_ctl;
    logic [SAMPLE_WIDTH-1:0] res_i;
    logic [SAMPLE_WIDTH-1:0] res_q;

    // Unpack the input transaction.
    assign sample_i    = s_tdata[SAMPLE_WIDTH-1:0];
    assign sample_q    = s_tdata[IDX_LO-1:SAMPLE_WIDTH];
    assign coeff_index = s_tdata[VAL_LO-1:IDX_LO];
    assign coeff_value = s_tdata[VAL_LO+COEFF_WIDTH-1:VAL_LO];
    assign opcode      = cfir_pkg::opcode_t'(s_tuser);

    cfir_regs #(
        .MAX_TAPS (MAX_TAPS)
    ) u_regs (
        .clk          (clk),
        .rst_n        (rst_n),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready),
        .tap_count    (tap_count),
        .taps_changed (taps_changed)
    );

    cfir_store #(
        .MAX_TAPS     (MAX_TAPS),
        .SAMPLE_WIDTH (SAMPLE_WIDTH),
        .COEFF_WIDTH  (COEFF_WIDTH)
    ) u_store (
        .clk        (clk),
        .dl_we      (dl_we),
        .dl_waddr   (dl_waddr),
        .dl_wdata_i (dl_wdata_i),
        .dl_wdata_q (dl_wdata_q),
        .cf_we      (cf_we),
        .cf_waddr   (cf_waddr),
        .cf_wdata   (cf_wdata),
        .rd_en      (rd_en),
        .dl_raddr   (dl_raddr),
        .cf_raddr   (cf_raddr),
        .rd_i       (rd_i),
        .rd_q       (rd_q),
        .rd_c       (rd_c)
    );

    cfir_mac #(
        .MAX_TAPS     (MAX_TAPS),
        .SAMPLE_WIDTH (SAMPLE_WIDTH),
        .COEFF_WIDTH  (COEFF_WIDTH)
    ) u_mac (
        .clk   (clk),
        .rst_n (rst_n),
        .ctl   (mac_ctl),
        .rd_i  (rd_i),
        .rd_q  (rd_q),
        .rd_c  (rd_c),
        .res_i (res_i),
        .res_q (res_q)
    );

    cfir_ctrl #(
        .MAX_TAPS     (MAX_TAPS),
        .SAMPLE_WIDTH (SAMPLE_WIDTH),
        .COEFF_WIDTH  (COEFF_WIDTH)
    ) u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .s_tvalid     (s_tvalid),
        .s_tready     (s_tready),
        .opcode       (opcode),
        .sample_i     (sample_i),
        .sample_q     (sample_q),
        .coeff_index  (coeff_index),
        .coeff_value  (coeff_value),
        .tap_count    (tap_count),
        .taps_changed (taps_changed),
        .dl_we        (dl_we),
        .dl_waddr     (dl_waddr),
        .dl_wdata_i   (dl_wdata_i),
        .dl_wdata_q   (dl_wdata_q),
        .cf_we        (cf_we),
        .cf_waddr     (cf_waddr),
        .cf_wdata     (cf_wdata),
        .rd_en        (rd_en),
        .dl_raddr     (dl_raddr),
        .cf_raddr     (cf_raddr),
        .mac_ctl      (mac_ctl),
        .res_i        (res_i),
        .res_q        (res_q),
        .m_tvalid     (m_tvalid),
        .m_tready     (m_tready),
        .m_tdata      (m_tdata)
    );

endmodule

`default_nettype wire

// ----- hdl/cfir_checker.sv -----
`default_nettype none

module cfir_checker #(
    parameter int SAMPLE_WIDTH = cfir_pkg::DEF_SAMPLE_WIDTH
) (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic                                s_tvalid,
    input  wire logic                                s_tready,
    input  wire logic                                s_tuser,
    input  wire logic                                m_tvalid,
    input  wire logic                                m_tready,
    input  wire logic [((2*SAMPLE_WIDTH+7)/8)*8-1:0] m_tdata
);

    logic s_acc;

    assign s_acc = s_tvalid && s_tready;

    // A sample transaction starts a tap walk, so the input side closes.
    a_sample_busy: assert property (@(posedge clk) disable iff (!rst_n)
        s_acc && (s_tuser == cfir_pkg::OP_FILTER) |=> !s_tready)
        else $error("input still ready right after a sample transaction");

    // A coefficient load leaves the input side ready.
    a_load_quick: assert property (@(posedge clk) disable iff (!rst_n)
        s_acc && (s_tuser == cfir_pkg::OP_LOAD) |=> s_tready)
        else $error("input not ready after a coefficient load");

    // A new result only appears at the end of a filtering pass.
    a_result_after_work: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_tvalid) |-> $past(!s_tready))
        else $error("result appeared without a filtering pass");

    // A stalled result holds.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("stalled result changed");

endmodule

bind complex_fir_filter_core cfir_checker #(
    .SAMPLE_WIDTH (SAMPLE_WIDTH)
) u_cfir_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

`default_nettype wire
